@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define PAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define PAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pas_pkg.sv @@
// ---------------------------------------------------------------------------
// pas_pkg
// Widths, register map, reset values and stage payload types of the scaler.
// ---------------------------------------------------------------------------
package pas_pkg;

   localparam int TYPE_W   = 8;
   localparam int CODE_W   = 16;
   localparam int VALUE_W  = 16;
   localparam int COUNT_W  = 2;
   localparam int FACTOR_W = 14;
   localparam int SPEED_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Interpolation numerator |fmax - fmin| * (mag - speed_low) and its divisor.
   localparam int NUM_W = FACTOR_W + SPEED_W;
   localparam int DEN_W = SPEED_W;

   // Magnitude times factor.
   localparam int PROD_W = VALUE_W + FACTOR_W;

   // Divide by 100 as multiply by ceil(2^36 / 100) and shift; exact below 2^29.
   localparam int RECIP_W     = 30;
   localparam int RECIP_SHIFT = 36;
   localparam int MUL_W       = PROD_W + RECIP_W;
   localparam int QUOT_W      = MUL_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 30'd687194768;

   localparam logic [VALUE_W-1:0] VALUE_MAX     = 16'h7FFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN     = 16'h8000;
   localparam logic [QUOT_W-1:0]  QUOT_POS_LIM  = 24'd32767;
   localparam logic [QUOT_W-1:0]  QUOT_NEG_LIM  = 24'd32768;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_TYPE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_CODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_LO   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_HI   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LOW   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_HIGH  = 3'd7;

   typedef struct packed {
      logic [TYPE_W-1:0]   match_type;
      logic [COUNT_W-1:0]  code_count;
      logic [CODE_W-1:0]   first_code;
      logic [CODE_W-1:0]   second_code;
      logic [FACTOR_W-1:0] factor_lo;
      logic [FACTOR_W-1:0] factor_hi;
      logic [SPEED_W-1:0]  speed_low;
      logic [SPEED_W-1:0]  speed_high;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      match_type:  8'd2,
      code_count:  2'd2,
      first_code:  16'd0,
      second_code: 16'd1,
      factor_lo:   14'd100,
      factor_hi:   14'd200,
      speed_low:   16'd2,
      speed_high:  16'd20
   };

   // Per-item data that rides along the pipeline next to the arithmetic.
   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value;
      logic [SPEED_W-1:0] mag;
      logic               use_min;
      logic               use_max;
      logic               dneg;
   } side_type;

endpackage

@@ rtl/pointer_speed_accel_scaler.sv @@
// ---------------------------------------------------------------------------
// pointer_speed_accel_scaler
// Linear pointer acceleration over a stream of motion events.
// ---------------------------------------------------------------------------
// Takes one event per cycle while the result side does not stall and returns
// one result per event, in order. Events whose type equals match_type and
// whose code equals one of the first code_count codes are scaled by a
// percent factor that changes linearly from the low-speed factor at
// speed_low to the high-speed factor at speed_high over the magnitude of
// the value; the result is value * factor / 100, truncated toward zero and
// clamped to 16 bits signed, and rsp_tuser flags it. Every other event
// comes back unchanged. The pipeline is the 14-stage divider that
// interpolates the factor, one quotient bit per stage, plus three front
// stages and four scaling stages. A stall on rsp_tready freezes the whole
// pipeline, and the input side keeps taking events while the output
// register is empty or being drained. Write the registers only while
// no transaction is in flight.
// ---------------------------------------------------------------------------
module pointer_speed_accel_scaler
   import pas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,    // [15:0] event_code, [31:16] event_value
   input  logic [TYPE_W-1:0]      req_tuser,    // [7:0] event_type

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [VALUE_W-1:0]     rsp_tdata,    // [15:0] out_value
   output logic                   rsp_tuser,    // [0] was_scaled

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                pipe_en;

   logic                fr_vld;
   side_type            fr_side;
   logic [NUM_W-1:0]    fr_num;
   logic [DEN_W-1:0]    fr_den;

   logic                dv_vld;
   side_type            dv_side;
   logic [FACTOR_W-1:0] dv_quo;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MATCH_TYPE:  cfg_in.match_type  = csr_wdata[TYPE_W-1:0];
            REG_CODE_COUNT:  cfg_in.code_count  = csr_wdata[COUNT_W-1:0];
            REG_FIRST_CODE:  cfg_in.first_code  = csr_wdata[CODE_W-1:0];
            REG_SECOND_CODE: cfg_in.second_code = csr_wdata[CODE_W-1:0];
            REG_FACTOR_LO:   cfg_in.factor_lo   = csr_wdata[FACTOR_W-1:0];
            REG_FACTOR_HI:   cfg_in.factor_hi   = csr_wdata[FACTOR_W-1:0];
            REG_SPEED_LOW:   cfg_in.speed_low   = csr_wdata[SPEED_W-1:0];
            REG_SPEED_HIGH:  cfg_in.speed_high  = csr_wdata[SPEED_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance every stage together unless a finished result is held back.
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   pas_front u_front (
      .clock    (clock),
      .reset    (reset),
      .pipe_en  (pipe_en),
      .cfg      (cfg_ff),
      .in_vld   (req_tvalid),
      .in_type  (req_tuser),
      .in_code  (req_tdata[15:0]),
      .in_value (req_tdata[31:16]),
      .out_vld  (fr_vld),
      .out_side (fr_side),
      .out_num  (fr_num),
      .out_den  (fr_den)
   );

   pas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .pipe_en  (pipe_en),
      .in_vld   (fr_vld),
      .in_side  (fr_side),
      .in_num   (fr_num),
      .in_den   (fr_den),
      .out_vld  (dv_vld),
      .out_side (dv_side),
      .out_quo  (dv_quo)
   );

   pas_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .pipe_en    (pipe_en),
      .cfg        (cfg_ff),
      .in_vld     (dv_vld),
      .in_side    (dv_side),
      .in_quo     (dv_quo),
      .out_vld    (rsp_tvalid),
      .out_value  (rsp_tdata),
      .out_scaled (rsp_tuser)
   );

endmodule

@@ rtl/pas_front.sv @@
// ---------------------------------------------------------------------------
// pas_front
// Match decode, magnitude, curve segment select and interpolation numerator.
// ---------------------------------------------------------------------------
module pas_front
   import pas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                pipe_en,
   input  cfg_type             cfg,
   input  logic                in_vld,
   input  logic [TYPE_W-1:0]   in_type,
   input  logic [CODE_W-1:0]   in_code,
   input  logic [VALUE_W-1:0]  in_value,
   output logic                out_vld,
   output side_type            out_side,
   output logic [NUM_W-1:0]    out_num,
   output logic [DEN_W-1:0]    out_den
);

   // stage 1: hit and magnitude
   logic               s1_vld_ff;
   logic               s1_hit_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [SPEED_W-1:0] s1_mag_ff;
   logic               hit_in;
   logic [SPEED_W-1:0] mag_in;

   // stage 2: segment select and operands
   logic                s2_vld_ff;
   side_type            s2_side_ff;
   logic [FACTOR_W-1:0] s2_dd_ff;
   logic [SPEED_W-1:0]  s2_off_ff;
   logic [DEN_W-1:0]    s2_den_ff;
   side_type            side_in;
   logic [FACTOR_W-1:0] dd_in;

   // stage 3: numerator product
   logic              s3_vld_ff;
   side_type          s3_side_ff;
   logic [NUM_W-1:0]  s3_num_ff;
   logic [DEN_W-1:0]  s3_den_ff;

   always_comb begin
      hit_in = 1'b0;
      if (in_type == cfg.match_type) begin
         if (cfg.code_count != 2'd0 && in_code == cfg.first_code) begin
            hit_in = 1'b1;
         end
         if (cfg.code_count[1] && in_code == cfg.second_code) begin
            hit_in = 1'b1;
         end
      end
      // most negative value wraps to 0x8000, read unsigned as 32768
      mag_in = in_value[VALUE_W-1] ? (~in_value + 1'b1) : in_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= in_vld;
      end
      if (pipe_en) begin
         s1_hit_ff   <= hit_in;
         s1_value_ff <= in_value;
         s1_mag_ff   <= mag_in;
      end
   end

   always_comb begin
      side_in.hit     = s1_hit_ff;
      side_in.value   = s1_value_ff;
      side_in.mag     = s1_mag_ff;
      side_in.use_min = (cfg.speed_high <= cfg.speed_low) || (s1_mag_ff <= cfg.speed_low);
      side_in.use_max = (s1_mag_ff >= cfg.speed_high);
      side_in.dneg    = (cfg.factor_hi < cfg.factor_lo);
      dd_in = side_in.dneg ? (cfg.factor_lo - cfg.factor_hi)
                           : (cfg.factor_hi - cfg.factor_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (pipe_en) begin
         s2_side_ff <= side_in;
         s2_dd_ff   <= dd_in;
         s2_off_ff  <= s1_mag_ff - cfg.speed_low;
         s2_den_ff  <= cfg.speed_high - cfg.speed_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (pipe_en) begin
         s3_side_ff <= s2_side_ff;
         s3_num_ff  <= NUM_W'(s2_dd_ff) * NUM_W'(s2_off_ff);
         s3_den_ff  <= s2_den_ff;
      end
   end

   assign out_vld  = s3_vld_ff;
   assign out_side = s3_side_ff;
   assign out_num  = s3_num_ff;
   assign out_den  = s3_den_ff;

endmodule

@@ rtl/pas_div.sv @@
// ---------------------------------------------------------------------------
// pas_div
// Restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module pas_div
   import pas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                pipe_en,
   input  logic                in_vld,
   input  side_type            in_side,
   input  logic [NUM_W-1:0]    in_num,
   input  logic [DEN_W-1:0]    in_den,
   output logic                out_vld,
   output side_type            out_side,
   output logic [FACTOR_W-1:0] out_quo
);

   // The quotient of an interpolated point never exceeds |fmax - fmin|,
   // so FACTOR_W quotient bits cover it.
   logic                vld_ff  [FACTOR_W];
   side_type            side_ff [FACTOR_W];
   logic [NUM_W-1:0]    rem_ff  [FACTOR_W];
   logic [FACTOR_W-1:0] quo_ff  [FACTOR_W];
   logic [DEN_W-1:0]    den_ff  [FACTOR_W];

   for (genvar k = 0; k < FACTOR_W; k++) begin : g_stage
      localparam int BIT = FACTOR_W - 1 - k;

      logic                vld_src;
      side_type            side_src;
      logic [NUM_W-1:0]    rem_src;
      logic [FACTOR_W-1:0] quo_src;
      logic [DEN_W-1:0]    den_src;
      logic [NUM_W-1:0]    trial;
      logic [NUM_W-1:0]    rem_in;
      logic [FACTOR_W-1:0] quo_in;

      if (k == 0) begin : g_head
         assign vld_src  = in_vld;
         assign side_src = in_side;
         assign rem_src  = in_num;
         assign quo_src  = '0;
         assign den_src  = in_den;
      end else begin : g_body
         assign vld_src  = vld_ff[k-1];
         assign side_src = side_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign den_src  = den_ff[k-1];
      end

      always_comb begin
         trial  = NUM_W'(den_src) << BIT;
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            quo_in = quo_src | (FACTOR_W'(1) << BIT);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (pipe_en) begin
            vld_ff[k] <= vld_src;
         end
         if (pipe_en) begin
            side_ff[k] <= side_src;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_src;
         end
      end
   end

   assign out_vld  = vld_ff[FACTOR_W-1];
   assign out_side = side_ff[FACTOR_W-1];
   assign out_quo  = quo_ff[FACTOR_W-1];

endmodule

@@ rtl/pas_scale.sv @@
// ---------------------------------------------------------------------------
// pas_scale
// Factor select, value scaling, divide by 100 and saturation.
// ---------------------------------------------------------------------------
module pas_scale
   import pas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                pipe_en,
   input  cfg_type             cfg,
   input  logic                in_vld,
   input  side_type            in_side,
   input  logic [FACTOR_W-1:0] in_quo,
   output logic                out_vld,
   output logic [VALUE_W-1:0]  out_value,
   output logic                out_scaled
);

   logic                s1_vld_ff;
   side_type            s1_side_ff;
   logic [FACTOR_W-1:0] s1_fac_ff;
   logic [FACTOR_W-1:0] fac_in;

   logic                s2_vld_ff;
   side_type            s2_side_ff;
   logic [PROD_W-1:0]   s2_prod_ff;

   logic                s3_vld_ff;
   side_type            s3_side_ff;
   logic [QUOT_W-1:0]   s3_quot_ff;
   logic [MUL_W-1:0]    recip_full;

   logic                s4_vld_ff;
   logic [VALUE_W-1:0]  s4_value_ff;
   logic                s4_scaled_ff;
   logic [VALUE_W-1:0]  value_in;

   always_comb begin
      if (in_side.use_min) begin
         fac_in = cfg.factor_lo;
      end else if (in_side.use_max) begin
         fac_in = cfg.factor_hi;
      end else if (in_side.dneg) begin
         fac_in = cfg.factor_lo - in_quo;
      end else begin
         fac_in = cfg.factor_lo + in_quo;
      end
   end

   always_comb begin
      recip_full = MUL_W'(s2_prod_ff) * MUL_W'(RECIP_MULT);
   end

   always_comb begin
      // truncate toward zero: divide the magnitude, then restore the sign
      if (!s3_side_ff.hit) begin
         value_in = s3_side_ff.value;
      end else if (s3_side_ff.value[VALUE_W-1]) begin
         value_in = (s3_quot_ff > QUOT_NEG_LIM) ? VALUE_MIN
                                                : (~s3_quot_ff[VALUE_W-1:0] + 1'b1);
      end else begin
         value_in = (s3_quot_ff > QUOT_POS_LIM) ? VALUE_MAX : s3_quot_ff[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (pipe_en) begin
         s1_side_ff   <= in_side;
         s1_fac_ff    <= fac_in;
         s2_side_ff   <= s1_side_ff;
         s2_prod_ff   <= PROD_W'(s1_side_ff.mag) * PROD_W'(s1_fac_ff);
         s3_side_ff   <= s2_side_ff;
         s3_quot_ff   <= recip_full[MUL_W-1:RECIP_SHIFT];
         s4_value_ff  <= value_in;
         s4_scaled_ff <= s3_side_ff.hit;
      end
   end

   assign out_vld    = s4_vld_ff;
   assign out_value  = s4_value_ff;
   assign out_scaled = s4_scaled_ff;

endmodule

@@ rtl/pas_checker.sv @@
// ---------------------------------------------------------------------------
// pas_checker
// Port-level checks of the scaler's stream handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pas_checker
   import pas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [VALUE_W-1:0]     rsp_tdata,
   input  logic                   rsp_tuser
);

   // A held result keeps its payload until taken.
   `PAS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // An empty output register never blocks the input side.
   `PAS_ASSERT(a_req_open, clock, reset, !rsp_tvalid |-> req_tready, "input stalled with empty output")

   // Taking a result frees the pipeline for a new transaction.
   `PAS_ASSERT_ALWAYS(a_drain_open, clock, rsp_tvalid && rsp_tready |-> req_tready, "input stalled while output drains")

   // Reset empties the pipeline.
   `PAS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind pointer_speed_accel_scaler pas_checker u_pas_checker (.*);
